// File: rtl/bats_pkg.sv
// bats_pkg: shared types and constants of the bond and torsion cosine stream
// used by bats_unit and bond_and_torsion_cosine_stream_top
package bats_pkg;

	localparam int DIST_BITS = 24;
	// wide enough for every intermediate of the torsion ratio
	localparam int WIDE_BITS = 4 * DIST_BITS + 40;
	localparam int CNT_BITS = 8;

	typedef logic signed [WIDE_BITS-1:0] wide_t;
	typedef logic [DIST_BITS-1:0] dist_t;

	localparam wide_t ONE_Q30 = wide_t'(64'sd1073741824);
	localparam wide_t ONE_Q60 = wide_t'(64'sd1152921504606846976);
	localparam wide_t PI_Q30 = wide_t'(64'sd3373259426);
	localparam wide_t HALF_PI_Q30 = wide_t'(64'sd1686629713);

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT,
		OP_ACOS
	} op_t;

	typedef struct packed {
		op_t op;
		logic [CNT_BITS-1:0] count;
	} cmd_t;

	typedef struct packed {
		logic chain_start;
		logic [23:0] d_near;
		logic [23:0] d_prev;
		logic [23:0] d_skip;
		logic [23:0] d_far;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] bond_cosine;
		logic [31:0] bond_angle;
		logic signed [31:0] torsion_cosine;
		logic [30:0] torsion_sine_abs;
		logic torsion_valid;
		logic degenerate;
	} out_item_t;

	// arctangent of 2^-i in Q2.30
	function automatic logic [31:0] atan_entry(input logic [5:0] i);
		logic [31:0] v;
		case (i)
			6'd0: v = 32'd843314857;
			6'd1: v = 32'd497837829;
			6'd2: v = 32'd263043837;
			6'd3: v = 32'd133525159;
			6'd4: v = 32'd67021687;
			6'd5: v = 32'd33543516;
			6'd6: v = 32'd16775851;
			6'd7: v = 32'd8388437;
			6'd8: v = 32'd4194283;
			6'd9: v = 32'd2097149;
			6'd10: v = 32'd1048576;
			default: begin
				if (i <= 6'd30) v = 32'd1 << (6'd30 - i);
				else v = 32'd0;
			end
		endcase
		return v;
	endfunction

endpackage

// File: rtl/bats_stream_if.sv
// bats_stream_if: valid/ready channel carrying one word of payload_t
// payload types come from bats_pkg
interface bats_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/bond_and_torsion_cosine_stream_top.sv
// bond_and_torsion_cosine_stream_top: sequencer over the shared bats_unit
// one atom word in, one angle word out; uses bats_pkg, bats_stream_if, bats_unit
// a saturated ratio skips the ratio steps and a zero bond distance skips the ratio request;
// a held result stalls the sequencer in S_FIN until the output word is taken
// one atom at a time: taken only in S_IDLE; the shared unit does one step a cycle
// reset: asynchronous active low, clears chain history and the sticky error
module bond_and_torsion_cosine_stream_top #(
	parameter int ACOS_ITERATIONS = 30
) (
	input logic clk,
	input logic arst_n,
	bats_stream_if.sink atom,
	bats_stream_if.source angles
);
	localparam int W = bats_pkg::WIDE_BITS;
	localparam int DB = bats_pkg::DIST_BITS;
	localparam int CB = bats_pkg::CNT_BITS;
	localparam int ACOS_STEPS = (ACOS_ITERATIONS < 48) ? ACOS_ITERATIONS : 48;
	// sqrt operands are left aligned so the unit reads two bits from the top
	localparam int SH_Q60 = W - 62;
	localparam int SH_INNER = W - (4 * DB + 4);

	typedef enum logic [4:0] {
		S_IDLE, S_SQA, S_SQB, S_SQS, S_AB, S_BC, S_BSQ, S_BSIN, S_ACOS, S_TCHK,
		S_CSQ, S_CSIN, S_UQ, S_EE, S_INNER, S_RT, S_PP, S_WW, S_QG, S_PE, S_PEC,
		S_RP, S_D, S_CW, S_WSQ, S_WSIN, S_FIN
	} state_t;

	state_t state_q;
	logic issued_q, start_q;
	bats_pkg::cmd_t cmd_q;
	bats_pkg::wide_t opa_q, opb_q;
	logic u_done;
	bats_pkg::wide_t u_res;

	bats_pkg::dist_t dn_q, dp_q, ds_q, df_q, prevd_q;
	logic signed [31:0] lastc_q, bc_q, cw_q;
	logic [31:0] ang_q;
	logic [30:0] sw_q;
	logic havep_q, err_q, tv_q;
	bats_pkg::wide_t sqa_q, sqb_q, sqs_q, ab_q, t_q, u_q, st_q, rt_q, g_q, qg_q, n_q;
	logic ovalid_q;
	bats_pkg::out_item_t odata_q;

	bats_pkg::wide_t num_w, e_w, inner_w, dn_w, dp_w, df_w, prevd_w, bc_w, ct_w, cw_w;
	bats_pkg::cmd_t issue_cmd;
	bats_pkg::wide_t issue_a, issue_b;

	assign dn_w = bats_pkg::wide_t'({1'b0, dn_q});
	assign dp_w = bats_pkg::wide_t'({1'b0, dp_q});
	assign df_w = bats_pkg::wide_t'({1'b0, df_q});
	assign prevd_w = bats_pkg::wide_t'({1'b0, prevd_q});
	assign bc_w = bats_pkg::wide_t'(bc_q);
	assign ct_w = bats_pkg::wide_t'(lastc_q);
	assign cw_w = bats_pkg::wide_t'(cw_q);
	assign num_w = sqa_q + sqb_q - sqs_q;
	assign e_w = sqs_q + sqb_q - sqa_q;
	assign inner_w = (u_q <<< 2) - t_q;

	// unit request for the current step
	always_comb begin
		issue_cmd.op = bats_pkg::OP_MUL;
		issue_cmd.count = CB'(DB);
		issue_a = '0;
		issue_b = '0;
		case (state_q)
			S_SQA: begin issue_a = dn_w; issue_b = dn_w; end
			S_SQB: begin issue_a = dp_w; issue_b = dp_w; end
			S_SQS: begin
				issue_a = bats_pkg::wide_t'({1'b0, ds_q});
				issue_b = bats_pkg::wide_t'({1'b0, ds_q});
			end
			S_AB: begin issue_a = dn_w; issue_b = dp_w; end
			S_BC: begin
				issue_cmd.op = bats_pkg::OP_DIV;
				issue_cmd.count = CB'(30);
				issue_a = num_w;
				issue_b = ab_q <<< 1;
			end
			S_BSQ: begin issue_cmd.count = CB'(31); issue_a = bc_w; issue_b = bc_w; end
			S_BSIN, S_CSIN, S_WSIN: begin
				issue_cmd.op = bats_pkg::OP_SQRT;
				issue_cmd.count = CB'(31);
				issue_a = (bats_pkg::ONE_Q60 - t_q) <<< SH_Q60;
			end
			S_ACOS: begin
				issue_cmd.op = bats_pkg::OP_ACOS;
				issue_cmd.count = CB'(ACOS_STEPS);
				issue_a = bc_w;
				issue_b = t_q;
			end
			S_CSQ: begin issue_cmd.count = CB'(31); issue_a = ct_w; issue_b = ct_w; end
			S_UQ: begin issue_cmd.count = CB'(2 * DB); issue_a = sqs_q; issue_b = sqb_q; end
			S_EE: begin issue_cmd.count = CB'(2 * DB + 1); issue_a = e_w; issue_b = e_w; end
			S_RT: begin
				issue_cmd.op = bats_pkg::OP_SQRT;
				issue_cmd.count = CB'(2 * DB + 2);
				issue_a = inner_w <<< SH_INNER;
			end
			S_PP: begin issue_a = prevd_w; issue_b = prevd_w; end
			S_WW: begin issue_a = df_w; issue_b = df_w; end
			S_QG: begin issue_a = g_q; issue_b = dp_w; end
			S_PE: begin issue_a = e_w; issue_b = prevd_w; end
			S_PEC: begin issue_cmd.count = CB'(31); issue_a = t_q; issue_b = ct_w; end
			S_RP: begin issue_a = rt_q; issue_b = prevd_w; end
			S_D: begin issue_cmd.count = CB'(31); issue_a = t_q; issue_b = st_q; end
			S_CW: begin
				issue_cmd.op = bats_pkg::OP_DIV;
				issue_cmd.count = CB'(30);
				issue_a = n_q;
				issue_b = t_q;
			end
			S_WSQ: begin issue_cmd.count = CB'(31); issue_a = cw_w; issue_b = cw_w; end
			default: ;
		endcase
	end

	bats_unit u_unit (
		.clk(clk),
		.arst_n(arst_n),
		.start(start_q),
		.cmd(cmd_q),
		.opa(opa_q),
		.opb(opb_q),
		.done(u_done),
		.result(u_res)
	);

	assign atom.ready = (state_q == S_IDLE);
	assign angles.valid = ovalid_q;
	assign angles.data = odata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_q <= 1'b0;
			start_q <= 1'b0;
			cmd_q <= '0;
			opa_q <= '0;
			opb_q <= '0;
			dn_q <= '0;
			dp_q <= '0;
			ds_q <= '0;
			df_q <= '0;
			prevd_q <= '0;
			lastc_q <= '0;
			bc_q <= '0;
			cw_q <= '0;
			ang_q <= '0;
			sw_q <= '0;
			havep_q <= 1'b0;
			err_q <= 1'b0;
			tv_q <= 1'b0;
			sqa_q <= '0;
			sqb_q <= '0;
			sqs_q <= '0;
			ab_q <= '0;
			t_q <= '0;
			u_q <= '0;
			st_q <= '0;
			rt_q <= '0;
			g_q <= '0;
			qg_q <= '0;
			n_q <= '0;
			ovalid_q <= 1'b0;
			odata_q <= '0;
		end else begin
			start_q <= 1'b0;
			if (ovalid_q && angles.ready && state_q != S_FIN) ovalid_q <= 1'b0;

			if (state_q == S_IDLE) begin
				if (atom.valid) begin
					dn_q <= atom.data.d_near;
					dp_q <= atom.data.d_prev;
					ds_q <= atom.data.d_skip;
					df_q <= atom.data.d_far;
					cw_q <= '0;
					sw_q <= '0;
					tv_q <= 1'b0;
					if (atom.data.chain_start) begin
						havep_q <= 1'b0;
						err_q <= 1'b0;
					end
					state_q <= S_SQA;
				end
			end else if (state_q == S_FIN) begin
				if (!ovalid_q || angles.ready) begin
					ovalid_q <= 1'b1;
					odata_q.bond_cosine <= bc_q;
					odata_q.bond_angle <= ang_q;
					odata_q.torsion_cosine <= cw_q;
					odata_q.torsion_sine_abs <= sw_q;
					odata_q.torsion_valid <= tv_q;
					odata_q.degenerate <= err_q;
					lastc_q <= bc_q;
					prevd_q <= dp_q;
					havep_q <= 1'b1;
					state_q <= S_IDLE;
				end
			end else if (state_q == S_TCHK) begin
				state_q <= (havep_q && !err_q) ? S_CSQ : S_FIN;
			end else if (state_q == S_INNER) begin
				if (inner_w[W-1] || inner_w == '0 || st_q == '0 || dp_q == '0 ||
						prevd_q == '0) begin
					err_q <= 1'b1;
					state_q <= S_FIN;
				end else begin
					state_q <= S_RT;
				end
			end else if (state_q == S_BC && (dn_q == '0 || dp_q == '0)) begin
				// zero bond distance: cosine pinned to the sign of the numerator
				err_q <= 1'b1;
				bc_q <= num_w[W-1] ? -32'sd1073741824 : 32'sd1073741824;
				state_q <= S_BSQ;
			end else if (!issued_q) begin
				issued_q <= 1'b1;
				start_q <= 1'b1;
				cmd_q <= issue_cmd;
				opa_q <= issue_a;
				opb_q <= issue_b;
			end else if (u_done) begin
				issued_q <= 1'b0;
				case (state_q)
					S_SQA: begin sqa_q <= u_res; state_q <= S_SQB; end
					S_SQB: begin sqb_q <= u_res; state_q <= S_SQS; end
					S_SQS: begin sqs_q <= u_res; state_q <= S_AB; end
					S_AB: begin ab_q <= u_res; state_q <= S_BC; end
					S_BC: begin bc_q <= u_res[31:0]; state_q <= S_BSQ; end
					S_BSQ: begin t_q <= u_res; state_q <= S_BSIN; end
					S_BSIN: begin t_q <= u_res; state_q <= S_ACOS; end
					S_ACOS: begin ang_q <= u_res[31:0]; state_q <= S_TCHK; end
					S_CSQ: begin t_q <= u_res; state_q <= S_CSIN; end
					S_CSIN: begin st_q <= u_res; state_q <= S_UQ; end
					S_UQ: begin u_q <= u_res; state_q <= S_EE; end
					S_EE: begin t_q <= u_res; state_q <= S_INNER; end
					S_RT: begin rt_q <= u_res; state_q <= S_PP; end
					S_PP: begin t_q <= u_res; state_q <= S_WW; end
					S_WW: begin g_q <= t_q + sqs_q - u_res; state_q <= S_QG; end
					S_QG: begin qg_q <= u_res; state_q <= S_PE; end
					S_PE: begin t_q <= u_res; state_q <= S_PEC; end
					S_PEC: begin n_q <= (qg_q <<< 30) - u_res; state_q <= S_RP; end
					S_RP: begin t_q <= u_res; state_q <= S_D; end
					S_D: begin t_q <= u_res; state_q <= S_CW; end
					S_CW: begin cw_q <= u_res[31:0]; state_q <= S_WSQ; end
					S_WSQ: begin t_q <= u_res; state_q <= S_WSIN; end
					S_WSIN: begin
						sw_q <= u_res[30:0];
						tv_q <= 1'b1;
						state_q <= S_FIN;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	a_done_only_when_issued: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> issued_q)
		else $error("unit result without a request");
	a_idle_nothing_pending: assert property (@(posedge clk) disable iff (!arst_n)
		atom.ready |-> !issued_q)
		else $error("idle with unit request pending");
	a_start_single: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> !start_q)
		else $error("unit start held");
	a_torsion_not_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid && angles.data.torsion_valid |-> !angles.data.degenerate)
		else $error("torsion word marked degenerate");
endmodule

// File: rtl/bats_unit.sv
// bats_unit: shared iterative arithmetic unit, one step per cycle
// multiply (shift-add), Q30 ratio (restoring), floor sqrt, arccos cordic; uses bats_pkg
module bats_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	input bats_pkg::cmd_t cmd,
	input bats_pkg::wide_t opa,
	input bats_pkg::wide_t opb,
	output logic done,
	output bats_pkg::wide_t result
);
	localparam int W = bats_pkg::WIDE_BITS;

	bats_pkg::op_t op_q;
	logic busy_q;
	logic neg_q;
	logic done_q;
	logic [bats_pkg::CNT_BITS-1:0] cnt_q;
	logic [5:0] idx_q;
	bats_pkg::wide_t a_q, b_q, acc_q, res_q;

	bats_pkg::wide_t mag_a, neg_opa, neg_opb, dbl, rem2, trial, xs, ys, atan_w, zc;
	logic div_sat;

	assign neg_opa = -opa;
	assign neg_opb = -opb;
	assign mag_a = opa[W-1] ? neg_opa : opa;
	assign div_sat = (cmd.op == bats_pkg::OP_DIV) && (mag_a >= opb);
	assign dbl = a_q <<< 1;
	assign rem2 = {b_q[W-3:0], a_q[W-1:W-2]};
	assign trial = {acc_q[W-3:0], 2'b01};
	assign xs = a_q >>> idx_q;
	assign ys = b_q >>> idx_q;
	assign atan_w = bats_pkg::wide_t'({1'b0, bats_pkg::atan_entry(idx_q)});

	always_comb begin
		if (acc_q[W-1]) zc = '0;
		else if (acc_q > bats_pkg::HALF_PI_Q30) zc = bats_pkg::HALF_PI_Q30;
		else zc = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= bats_pkg::OP_MUL;
			busy_q <= 1'b0;
			neg_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
			a_q <= '0;
			b_q <= '0;
			acc_q <= '0;
			res_q <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				op_q <= cmd.op;
				busy_q <= 1'b1;
				// saturated ratio: no steps, result is one with the sign of the dividend
				cnt_q <= div_sat ? '0 : cmd.count;
				idx_q <= '0;
				acc_q <= div_sat ? bats_pkg::ONE_Q30 : '0;
				case (cmd.op)
					bats_pkg::OP_MUL: begin
						// negative multiplier: negate both so the loop sees a magnitude
						a_q <= opb[W-1] ? neg_opa : opa;
						b_q <= opb[W-1] ? neg_opb : opb;
					end
					bats_pkg::OP_DIV: begin
						neg_q <= opa[W-1];
						a_q <= mag_a;
						b_q <= opb;
					end
					bats_pkg::OP_SQRT: begin
						a_q <= opa;
						b_q <= '0;
					end
					bats_pkg::OP_ACOS: begin
						neg_q <= opa[W-1];
						a_q <= mag_a;
						b_q <= opb;
					end
					default: ;
				endcase
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
					case (op_q)
						bats_pkg::OP_MUL: begin
							if (b_q[0]) acc_q <= acc_q + a_q;
							a_q <= dbl;
							b_q <= b_q >>> 1;
						end
						bats_pkg::OP_DIV: begin
							if (dbl >= b_q) begin
								a_q <= dbl - b_q;
								acc_q <= {acc_q[W-2:0], 1'b1};
							end else begin
								a_q <= dbl;
								acc_q <= {acc_q[W-2:0], 1'b0};
							end
						end
						bats_pkg::OP_SQRT: begin
							a_q <= a_q <<< 2;
							if ($unsigned(rem2) >= $unsigned(trial)) begin
								b_q <= rem2 - trial;
								acc_q <= {acc_q[W-2:0], 1'b1};
							end else begin
								b_q <= rem2;
								acc_q <= {acc_q[W-2:0], 1'b0};
							end
						end
						bats_pkg::OP_ACOS: begin
							idx_q <= idx_q + 1'b1;
							if (!b_q[W-1] && b_q != '0) begin
								a_q <= a_q + ys;
								b_q <= b_q - xs;
								acc_q <= acc_q + atan_w;
							end else if (b_q[W-1]) begin
								a_q <= a_q - ys;
								b_q <= b_q + xs;
								acc_q <= acc_q - atan_w;
							end
						end
						default: ;
					endcase
				end else begin
					busy_q <= 1'b0;
					case (op_q)
						bats_pkg::OP_DIV: res_q <= neg_q ? -acc_q : acc_q;
						bats_pkg::OP_ACOS: res_q <= neg_q ? bats_pkg::PI_Q30 - zc : zc;
						default: res_q <= acc_q;
					endcase
				end
			end
		end
	end

	assign done = done_q;
	assign result = res_q;

	a_no_start_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("unit started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("unit done without work");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("unit done while busy");
endmodule
